[hdl/ctbf_pkg.sv]
package ctbf_pkg;

  localparam int LEN_W = 22;
  localparam int COUNT_W = 24;
  localparam int TOTAL_W = 32;
  localparam logic [LEN_W-1:0] LEN_MAX = 22'h3FFFFF;
  localparam logic [7:0] ASCII_0 = 8'h30;
  localparam logic [7:0] ASCII_9 = 8'h39;
  localparam logic [COUNT_W-1:0] RADIX = 24'd10;

  localparam logic [1:0] ST_PENDING = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_DISCARD = 2'd2;
  localparam logic [1:0] ST_WRITTEN = 2'd3;

  localparam logic [1:0] KIND_FIXED = 2'd0;
  localparam logic [1:0] KIND_DECIMAL = 2'd1;
  localparam logic [1:0] KIND_TERM = 2'd2;

  localparam logic OP_PUSH = 1'b0;

  typedef enum logic [1:0] {
    MODE_MATCH = 2'd0,
    MODE_COUNT = 2'd1,
    MODE_TERM = 2'd2
  } mode_t;

  // One strobe per controller step.
  typedef struct packed {
    logic accept;
    logic cmp;
    logic sel;
    logic kind;
    logic digit;
    logic mul;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
    logic needs_eval;
    logic kind_emit;
    logic kind_digit;
    logic digit_done;
    logic digit_bad;
  } sts_t;

  function automatic logic [LEN_W-1:0] sat22(input logic [TOTAL_W:0] v);
    if (v > {11'd0, LEN_MAX}) begin
      return LEN_MAX;
    end
    return v[LEN_W-1:0];
  endfunction

endpackage

[hdl/command_table_byte_framer_unit.sv]
// Command framer for a printer byte stream. Each input transfer either writes one
// command table entry (answered with status 3) or pushes one stream byte, and every
// input transfer yields exactly one output transfer carrying status, matched entry and
// payload length. A table write, or a byte that arrives while a payload is being
// counted or scanned for its terminator, is answered in the cycle after it is taken. A
// byte in matching mode runs through a prefix compare, a longest-match select and a
// kind decision. Its result is registered from the kind decision when that
// settles it (an undecided buffer, an unknown prefix, an invalid kind or a terminator
// entry), and from a final step after it for a fixed-length entry. For a decimal
// length field, one shared step converts one ASCII digit per cycle, a further pass
// of that step sees the count complete, and a multiply by the element size and the
// final step follow; a bad digit ends the conversion early. One item is in flight at
// a time; a new item is taken once the output register is free or is being emptied.
module command_table_byte_framer_unit #(
  parameter int TABLE_DEPTH = 16,
  parameter int PREFIX_MAX = 4,
  parameter int DIGITS_MAX = 4,
  parameter int BUFFER_DEPTH = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        operation,
  input  logic [7:0]                  data_byte,
  input  logic [3:0]                  entry_index,
  input  logic [31:0]                 entry_prefix,
  input  logic [2:0]                  entry_prefix_len,
  input  logic [1:0]                  entry_kind,
  input  logic [15:0]                 entry_fixed_len,
  input  logic [2:0]                  entry_digit_count,
  input  logic [7:0]                  entry_element_size,
  input  logic [7:0]                  entry_end_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [3:0]                  matched_entry,
  output logic [ctbf_pkg::LEN_W-1:0]  payload_length
);
  import ctbf_pkg::*;

  // The controller sequences the evaluation steps; the datapath holds the table,
  // the match buffer, the parse state and the output register.
  cmd_t cmd;
  sts_t sts;

  ctbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ctbf_datapath #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .PREFIX_MAX   (PREFIX_MAX),
    .DIGITS_MAX   (DIGITS_MAX),
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .operation          (operation),
    .data_byte          (data_byte),
    .entry_index        (entry_index),
    .entry_prefix       (entry_prefix),
    .entry_prefix_len   (entry_prefix_len),
    .entry_kind         (entry_kind),
    .entry_fixed_len    (entry_fixed_len),
    .entry_digit_count  (entry_digit_count),
    .entry_element_size (entry_element_size),
    .entry_end_byte     (entry_end_byte),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .status             (status),
    .matched_entry      (matched_entry),
    .payload_length     (payload_length)
  );

endmodule

[hdl/ctbf_ctrl.sv]
module ctbf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ctbf_pkg::sts_t sts,
  output ctbf_pkg::cmd_t cmd
);
  import ctbf_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CMP   = 7'b0000010,
    S_SEL   = 7'b0000100,
    S_KIND  = 7'b0001000,
    S_DIGIT = 7'b0010000,
    S_MUL   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE) && !sts.out_busy;

  always_comb begin
    cmd = '0;
    cmd.accept = in_valid && in_ready;
    cmd.cmp = (state == S_CMP);
    cmd.sel = (state == S_SEL);
    cmd.kind = (state == S_KIND);
    cmd.digit = (state == S_DIGIT);
    cmd.mul = (state == S_MUL);
    cmd.fin = (state == S_FIN);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.accept && sts.needs_eval) state_next = S_CMP;
      end
      S_CMP: state_next = S_SEL;
      S_SEL: state_next = S_KIND;
      S_KIND: begin
        if (sts.kind_emit) state_next = S_IDLE;
        else if (sts.kind_digit) state_next = S_DIGIT;
        else state_next = S_FIN;
      end
      S_DIGIT: begin
        if (sts.digit_done) state_next = S_MUL;
        else if (sts.digit_bad) state_next = S_IDLE;
      end
      S_MUL: state_next = S_FIN;
      S_FIN: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

[hdl/ctbf_datapath.sv]
module ctbf_datapath #(
  parameter int TABLE_DEPTH = 16,
  parameter int PREFIX_MAX = 4,
  parameter int DIGITS_MAX = 4,
  parameter int BUFFER_DEPTH = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ctbf_pkg::cmd_t              cmd,
  output ctbf_pkg::sts_t              sts,
  input  logic                        operation,
  input  logic [7:0]                  data_byte,
  input  logic [3:0]                  entry_index,
  input  logic [31:0]                 entry_prefix,
  input  logic [2:0]                  entry_prefix_len,
  input  logic [1:0]                  entry_kind,
  input  logic [15:0]                 entry_fixed_len,
  input  logic [2:0]                  entry_digit_count,
  input  logic [7:0]                  entry_element_size,
  input  logic [7:0]                  entry_end_byte,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [1:0]                  status,
  output logic [3:0]                  matched_entry,
  output logic [ctbf_pkg::LEN_W-1:0]  payload_length
);
  import ctbf_pkg::*;

  localparam int TIW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FW = $clog2(BUFFER_DEPTH + 1);
  localparam int BIW = $clog2(BUFFER_DEPTH);
  localparam int PLIM = (PREFIX_MAX < 4) ? PREFIX_MAX : 4;

  // Command table.
  logic [31:0] pfx [TABLE_DEPTH];
  logic [2:0]  alen [TABLE_DEPTH];
  logic [1:0]  akind [TABLE_DEPTH];
  logic [15:0] afix [TABLE_DEPTH];
  logic [2:0]  adig [TABLE_DEPTH];
  logic [7:0]  aelem [TABLE_DEPTH];
  logic [7:0]  aend [TABLE_DEPTH];

  // Parser state.
  logic [7:0]       buf_q [BUFFER_DEPTH];
  logic [FW-1:0]    fill;
  mode_t            mode;
  logic [LEN_W-1:0] bytes_left;
  logic [7:0]       end_byte;
  logic [TIW-1:0]   cur_entry;
  logic [LEN_W-1:0] seen;

  // Evaluation pipeline registers.
  logic [TABLE_DEPTH-1:0] part_flag, full_flag;
  logic                   any_part;
  logic [2:0]             best_len;
  logic [TIW-1:0]         best;
  logic [COUNT_W-1:0]     cnt;
  logic [2:0]             di;
  logic [TOTAL_W-1:0]     total;
  logic [FW-1:0]          have;

  // Prefix compare of every entry against the buffer head.
  logic [TABLE_DEPTH-1:0] part_c, full_c;
  always_comb begin
    logic [7:0] bx [4];
    logic ok;
    logic en;
    for (int i = 0; i < 4; i++) begin
      bx[i] = buf_q[BIW'(i % BUFFER_DEPTH)];
    end
    for (int e = 0; e < TABLE_DEPTH; e++) begin
      ok = 1'b1;
      for (int i = 0; i < 4; i++) begin
        if ((i < 32'(alen[e])) && (i < 32'(fill)) && (pfx[e][8*i +: 8] != bx[i])) begin
          ok = 1'b0;
        end
      end
      en = (alen[e] != 3'd0) && (32'(alen[e]) <= PLIM);
      part_c[e] = en && ok && (32'(alen[e]) > 32'(fill));
      full_c[e] = en && ok && (32'(alen[e]) <= 32'(fill));
    end
  end

  // Longest full match, lowest index first within one length.
  logic [2:0]     bl_c;
  logic [TIW-1:0] best_c;
  always_comb begin
    logic           has_l [5];
    logic [TIW-1:0] idx_l [5];
    for (int l = 0; l < 5; l++) begin
      has_l[l] = 1'b0;
      idx_l[l] = '0;
      for (int e = TABLE_DEPTH - 1; e >= 0; e--) begin
        if (full_flag[e] && (32'(alen[e]) == l)) begin
          has_l[l] = 1'b1;
          idx_l[l] = TIW'(e);
        end
      end
    end
    bl_c = 3'd0;
    best_c = '0;
    for (int l = 1; l < 5; l++) begin
      if (has_l[l]) begin
        bl_c = 3'(l);
        best_c = idx_l[l];
      end
    end
  end

  logic [1:0]  k_kind;
  logic [2:0]  k_dig;
  logic [FW-1:0] dlen;
  logic        overflow;
  logic        dec_ok;
  assign k_kind = akind[best];
  assign k_dig = adig[best];
  assign dlen = fill - FW'(best_len);
  assign overflow = (32'(fill) >= BUFFER_DEPTH);
  assign dec_ok = (k_kind == KIND_DECIMAL) && (32'(k_dig) <= DIGITS_MAX);

  // Digit step.
  logic [5:0]   dpos;
  logic [7:0]   dchar;
  logic         dbad;
  assign dpos = 6'(best_len) + 6'(di);
  assign dchar = buf_q[BIW'(dpos)];
  assign dbad = (dchar < ASCII_0) || (dchar > ASCII_9);

  // Count and terminator mode handling of one pushed byte.
  logic [LEN_W-1:0] seen_inc, bl_dec;
  assign seen_inc = sat22(33'(seen) + 33'd1);
  assign bl_dec = (bytes_left != '0) ? bytes_left - 22'd1 : bytes_left;

  logic fin_ge;
  assign fin_ge = ({{(TOTAL_W - FW){1'b0}}, have} >= total);

  always_comb begin
    sts.out_busy = out_valid && !out_ready;
    sts.needs_eval = (operation == OP_PUSH) && (mode == MODE_MATCH);
    sts.kind_digit = !any_part && (best_len != 3'd0) && dec_ok
                     && (32'(dlen) >= 32'(k_dig));
    sts.kind_emit = any_part || (best_len == 3'd0)
                    || !((k_kind == KIND_FIXED) || dec_ok) || dec_ok && !sts.kind_digit;
    sts.digit_done = (di == k_dig);
    sts.digit_bad = dbad;
  end

  // Result of the current step.
  logic             emit;
  logic [1:0]       e_st;
  logic [3:0]       e_ent;
  logic [LEN_W-1:0] e_len;
  always_comb begin
    emit = 1'b0;
    e_st = ST_PENDING;
    e_ent = '0;
    e_len = '0;
    if (cmd.accept && !sts.needs_eval) begin
      emit = 1'b1;
      if (operation != OP_PUSH) begin
        e_st = ST_WRITTEN;
      end else if (mode == MODE_COUNT) begin
        if (bl_dec == '0) begin
          e_st = ST_DONE;
          e_ent = 4'(cur_entry);
          e_len = seen_inc;
        end
      end else if (data_byte == end_byte) begin
        e_st = ST_DONE;
        e_ent = 4'(cur_entry);
        e_len = seen_inc;
      end
    end else if (cmd.kind && sts.kind_emit) begin
      emit = 1'b1;
      if (any_part || (dec_ok && best_len != 3'd0)) begin
        e_st = overflow ? ST_DISCARD : ST_PENDING;
      end else if (best_len == 3'd0 || k_kind != KIND_TERM) begin
        e_st = ST_DISCARD;
      end
    end else if (cmd.digit && !sts.digit_done && dbad) begin
      emit = 1'b1;
      e_st = ST_DISCARD;
    end else if (cmd.fin) begin
      emit = 1'b1;
      if (fin_ge) begin
        e_st = ST_DONE;
        e_ent = 4'(best);
        e_len = LEN_W'(dlen);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (emit) begin
      status <= e_st;
      matched_entry <= e_ent;
      payload_length <= e_len;
    end
  end

  // Table writes.
  logic [TIW-1:0] widx;
  assign widx = TIW'(entry_index);
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < TABLE_DEPTH; e++) alen[e] <= 3'd0;
    end else if (cmd.accept && operation != OP_PUSH && 32'(entry_index) < TABLE_DEPTH) begin
      alen[widx] <= entry_prefix_len;
    end
    if (cmd.accept && operation != OP_PUSH && 32'(entry_index) < TABLE_DEPTH) begin
      pfx[widx] <= entry_prefix;
      akind[widx] <= entry_kind;
      afix[widx] <= entry_fixed_len;
      adig[widx] <= entry_digit_count;
      aelem[widx] <= entry_element_size;
      aend[widx] <= entry_end_byte;
    end
  end

  // Parser state and evaluation steps.
  always_ff @(posedge clk) begin
    if (cmd.accept && sts.needs_eval) buf_q[BIW'(fill)] <= data_byte;
    if (cmd.cmp) begin
      part_flag <= part_c;
      full_flag <= full_c;
    end
    if (cmd.sel) begin
      any_part <= |part_flag;
      best_len <= bl_c;
      best <= best_c;
    end
    if (cmd.kind) begin
      total <= TOTAL_W'(afix[best]);
      have <= dlen;
      cnt <= '0;
      di <= 3'd0;
    end
    if (cmd.digit && !sts.digit_done) begin
      cnt <= COUNT_W'(cnt * RADIX) + COUNT_W'(dchar - ASCII_0);
      di <= di + 3'd1;
    end
    if (cmd.mul) begin
      total <= TOTAL_W'(32'(cnt) * 32'(aelem[best]));
      have <= dlen - FW'(k_dig);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      mode <= MODE_MATCH;
      bytes_left <= '0;
      end_byte <= '0;
      cur_entry <= '0;
      seen <= '0;
    end else begin
      if (cmd.accept && operation == OP_PUSH) begin
        case (mode)
          MODE_MATCH: fill <= fill + FW'(1);
          MODE_COUNT: begin
            seen <= seen_inc;
            bytes_left <= bl_dec;
            if (bl_dec == '0) mode <= MODE_MATCH;
          end
          MODE_TERM: begin
            seen <= seen_inc;
            if (data_byte == end_byte) mode <= MODE_MATCH;
          end
          default: mode <= MODE_MATCH;
        endcase
        if (mode != MODE_MATCH) fill <= '0;
      end
      if (cmd.kind && sts.kind_emit) begin
        if (e_st == ST_DISCARD) begin
          fill <= '0;
        end else if (!any_part && !dec_ok) begin
          mode <= MODE_TERM;
          end_byte <= aend[best];
          cur_entry <= best;
          seen <= LEN_W'(dlen);
          fill <= '0;
        end
      end
      if (cmd.digit && !sts.digit_done && dbad) fill <= '0;
      if (cmd.fin) begin
        fill <= '0;
        if (!fin_ge) begin
          mode <= MODE_COUNT;
          bytes_left <= sat22(33'(total) - 33'(have));
          cur_entry <= best;
          seen <= LEN_W'(dlen);
        end
      end
    end
  end

endmodule
